// ----- design/slcg_pkg.sv -----
// Shared constants and controller/datapath command and status types for the shuffled LCG.
package slcg_pkg;

    // Field widths.
    localparam int SAMPLE_W = 31;
    localparam int FRAC_W   = 24;
    localparam int MULT_W   = 15;

    // Generator constants: multiplier and Mersenne prime modulus.
    localparam logic [MULT_W-1:0]   LCG_MULT = 15'd16807;
    localparam logic [SAMPLE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

    // Largest fraction handed out, 2^24 * (1 - 1.2e-7) rounded down.
    localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777213;

    // Warm-up runs this many steps beyond the table depth.
    localparam int WARM_EXTRA = 8;

    // Default shuffle table depth.
    localparam int DEFAULT_TABLE_DEPTH = 32;

    // Operation codes of a request word.
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic seed_load;   // load reduced seed, preset warm-up counter
        logic mul;         // register generator and slot reciprocal products
        logic warm_fold;   // reduce product, fill table, count down
        logic draw_fold;   // reduce product, register the slot index
        logic mem_access;  // read the slot, write the new generator word back
        logic out_load;    // load the result word and update last output
    } slcg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic unseeded;    // no seed taken since reset
        logic cnt_zero;    // final warm-up step
        logic out_stall;   // result register full and not being taken
    } slcg_status_t;

endpackage

// ----- design/slcg_if.sv -----
// Request and result channel interfaces of the shuffled LCG.
interface slcg_req_if import slcg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [SAMPLE_W-1:0] seed_value;

    modport source (output valid, operation, seed_value, input ready);
    modport sink   (input valid, operation, seed_value, output ready);
endinterface

interface slcg_res_if import slcg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [FRAC_W-1:0]   fraction;

    modport source (output valid, sample, fraction, input ready);
    modport sink   (input valid, sample, fraction, output ready);
endinterface

// ----- design/slcg_datapath.sv -----
// Datapath of the shuffled LCG: modular multiplier, slot divider, shuffle memory, result register.
module slcg_datapath import slcg_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  slcg_cmd_t           cmd,
    output slcg_status_t        status,
    input  logic [SAMPLE_W-1:0] seed_value,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [SAMPLE_W-1:0] sample,
    output logic [FRAC_W-1:0]   fraction
);

    localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + WARM_EXTRA);
    localparam int RW     = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W = SAMPLE_W + MULT_W;
    localparam int QD_W   = SAMPLE_W + RW;

    // Slot divisor and its truncated reciprocal scaled by 2^31.
    localparam logic [63:0] SLOT_DIV_W = 64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH);
    localparam logic [63:0] RECIP_W    = (64'd1 << SAMPLE_W) / SLOT_DIV_W;
    localparam logic [SAMPLE_W-1:0] SLOT_DIV = SAMPLE_W'(SLOT_DIV_W);
    localparam logic [RW-1:0]       RECIP    = RW'(RECIP_W);
    localparam logic [CW-1:0]       CNT_LOAD = CW'(TABLE_DEPTH + WARM_EXTRA - 1);
    localparam logic [CW-1:0]       CNT_TOP  = CW'(TABLE_DEPTH);
    localparam logic [RW:0]         SLOT_TOP = (RW + 1)'(TABLE_DEPTH - 1);

    logic [SAMPLE_W-1:0] lcg_reg;
    logic [SAMPLE_W-1:0] last_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [QD_W-1:0]     recip_reg;
    logic [IW-1:0]       slot_reg;
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [CW-1:0]       cnt_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [FRAC_W-1:0]   fraction_reg;

    logic [SAMPLE_W-1:0] shuffle_mem [TABLE_DEPTH];

    logic [SAMPLE_W-1:0] seed_red;
    logic [SAMPLE_W:0]   fold_sum;
    logic [SAMPLE_W-1:0] fold_value;
    logic [RW-1:0]       q_est;
    logic [QD_W-1:0]     q_prod;
    logic [QD_W-1:0]     q_rem;
    logic [RW:0]         slot_q;
    logic [IW-1:0]       slot_next;
    logic                cnt_in_table;
    logic                mem_we;
    logic [IW-1:0]       mem_addr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic [FRAC_W-1:0]   frac_q0;
    logic [SAMPLE_W:0]   frac_sum;
    logic [FRAC_W:0]     frac_raw;
    logic [FRAC_W-1:0]   fraction_next;

    // A seed of zero, or one equal to the modulus, becomes one.
    assign seed_red = (seed_value == '0 || seed_value == LCG_MOD) ? SAMPLE_W'(1) : seed_value;

    // Mersenne reduction: low word plus high part, then at most one subtraction.
    always_comb
    begin
        fold_sum = {1'b0, prod_reg[SAMPLE_W-1:0]}
                 + (SAMPLE_W + 1)'(prod_reg[PROD_W-1:SAMPLE_W]);
        if (fold_sum >= {1'b0, LCG_MOD})
        begin
            fold_value = SAMPLE_W'(fold_sum - {1'b0, LCG_MOD});
        end
        else
        begin
            fold_value = fold_sum[SAMPLE_W-1:0];
        end
    end

    // Slot index: reciprocal estimate, then one correction step and a clamp.
    always_comb
    begin
        q_est  = recip_reg[SAMPLE_W +: RW];
        q_prod = QD_W'(q_est) * QD_W'(SLOT_DIV);
        q_rem  = QD_W'(last_reg) - q_prod;
        slot_q = {1'b0, q_est} + (RW + 1)'(q_rem >= QD_W'(SLOT_DIV));
        if (slot_q > SLOT_TOP)
        begin
            slot_next = SLOT_TOP[IW-1:0];
        end
        else
        begin
            slot_next = slot_q[IW-1:0];
        end
    end

    // Fraction: floor(x * 2^24 / (2^31 - 1)) split at bit 7, clamped.
    always_comb
    begin
        frac_q0  = rdata_reg[SAMPLE_W-1:7];
        frac_sum = {1'b0, rdata_reg[6:0], 24'd0} + (SAMPLE_W + 1)'(frac_q0);
        frac_raw = (FRAC_W + 1)'(frac_q0) + (FRAC_W + 1)'(frac_sum >= {1'b0, LCG_MOD});
        if (frac_raw > (FRAC_W + 1)'(FRAC_MAX))
        begin
            fraction_next = FRAC_MAX;
        end
        else
        begin
            fraction_next = frac_raw[FRAC_W-1:0];
        end
    end

    // Memory port selection: warm-up fill or draw swap.
    assign cnt_in_table = cnt_reg < CNT_TOP;
    assign mem_we       = (cmd.warm_fold && cnt_in_table) || cmd.mem_access;
    assign mem_addr     = cmd.mem_access ? slot_reg : cnt_reg[IW-1:0];
    assign mem_wdata    = cmd.mem_access ? lcg_reg : fold_value;

    // Shuffle memory, read before write at the same slot.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shuffle_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_access)
        begin
            rdata_reg <= shuffle_mem[mem_addr];
        end
    end

    // Multiplier stage and slot register.
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg  <= PROD_W'(lcg_reg) * PROD_W'(LCG_MULT);
            recip_reg <= QD_W'(last_reg) * QD_W'(RECIP);
        end
        if (cmd.draw_fold)
        begin
            slot_reg <= slot_next;
        end
    end

    // Generator word and warm-up counter.
    always_ff @(posedge clk)
    begin
        if (cmd.seed_load)
        begin
            lcg_reg <= seed_red;
            cnt_reg <= CNT_LOAD;
        end
        else if (cmd.warm_fold)
        begin
            lcg_reg <= fold_value;
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
        else if (cmd.draw_fold)
        begin
            lcg_reg <= fold_value;
        end
    end

    // Last output word; zero marks the generator as unseeded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (cmd.warm_fold && cnt_reg == '0)
        begin
            last_reg <= fold_value;
        end
        else if (cmd.out_load)
        begin
            last_reg <= rdata_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sample_reg   <= rdata_reg;
            fraction_reg <= fraction_next;
        end
    end

    assign status.unseeded  = (last_reg == '0);
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.out_stall = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign fraction  = fraction_reg;

    // The generator word never falls into the zero or modulus fixed points.
    a_lcg_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.warm_fold || cmd.draw_fold) |=> (lcg_reg != '0 && lcg_reg != LCG_MOD))
        else $error("generator word left the multiplicative group");

    // The final warm-up step leaves the last output equal to the generator word.
    a_warm_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.warm_fold && status.cnt_zero) |=> (last_reg == lcg_reg))
        else $error("warm-up did not set the last output");

    // A delivered word is a valid sample and its fraction respects the clamp.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (sample_reg != '0 && sample_reg != LCG_MOD
                          && fraction_reg <= FRAC_MAX && last_reg == sample_reg))
        else $error("result word out of range");

endmodule

// ----- design/slcg_ctrl.sv -----
// Controller state machine of the shuffled LCG: sequences seeding, warm-up and draws.
module slcg_ctrl import slcg_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_operation,
    output logic         in_ready,
    input  slcg_status_t status,
    output slcg_cmd_t    cmd
);

    typedef enum logic [6:0] {
        IDLE  = 7'b0000001,
        WMUL  = 7'b0000010,
        WFOLD = 7'b0000100,
        DMUL  = 7'b0001000,
        DFOLD = 7'b0010000,
        DMEM  = 7'b0100000,
        DOUT  = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_operation == OP_RESEED || status.unseeded)
                    begin
                        cmd.seed_load = 1'b1;
                        state_next    = WMUL;
                    end
                    else
                    begin
                        state_next = DMUL;
                    end
                end
            end
            WMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = WFOLD;
            end
            WFOLD:
            begin
                cmd.warm_fold = 1'b1;
                state_next    = status.cnt_zero ? DMUL : WMUL;
            end
            DMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = DFOLD;
            end
            DFOLD:
            begin
                cmd.draw_fold = 1'b1;
                state_next    = DMEM;
            end
            DMEM:
            begin
                cmd.mem_access = 1'b1;
                state_next     = DOUT;
            end
            DOUT:
            begin
                if (!status.out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/shuffled_lcg_random_generator.sv -----
// Top level of the shuffled LCG random generator: channels, controller and datapath.
//
// Each word on the req channel asks for one random number; each asks for exactly one
// word on the res channel. operation OP_DRAW takes the next number, OP_RESEED loads
// seed_value (zero or 2^31-1 count as one) and then draws. The first draw after reset
// seeds from its own seed_value.
// A draw goes from acceptance to result in these steps: acceptance, the 31x15 modular
// multiply, its Mersenne reduction together with the slot division, the shuffle
// memory swap, and the result register load. The next word is accepted in the cycle
// after the result is loaded, so draws do not overlap. A reseed adds a warm-up, run
// by the multiply and reduce loop that fills the table; req.ready stays low meanwhile.
// Reset clears the controller and marks the generator unseeded; the table needs no
// clearing since the warm-up writes every entry before any is read.
// The result register holds a word until res.ready takes it. A new request is still
// accepted meanwhile; its result waits in the final step until the register frees.
module shuffled_lcg_random_generator import slcg_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    slcg_req_if.sink   req,
    slcg_res_if.source res
);

    slcg_cmd_t    cmd;
    slcg_status_t status;

    // Sequencing of seeding, warm-up and draws.
    slcg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_operation (req.operation),
        .in_ready     (req.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic, shuffle memory and result register.
    slcg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .seed_value (req.seed_value),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .sample     (res.sample),
        .fraction   (res.fraction)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the shuffled LCG random generator, with its own number predictor.
`timescale 1ns / 1ps

module tb;
    import slcg_pkg::*;

    localparam int DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int SLOT_DIV = 1 + (int'(LCG_MOD) - 1) / DEPTH;
    localparam int N_RANDOM = 650;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [FRAC_W-1:0]   fraction;
    } number_t;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] seed;
    } request_row_t;

    logic clk;
    logic rst_n;

    slcg_req_if req ();
    slcg_res_if res ();

    shuffled_lcg_random_generator #(.TABLE_DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source)
    );

    // Predictor state: core generator, shuffle slots and the previous sample.
    logic [SAMPLE_W-1:0] gen_state;
    logic [SAMPLE_W-1:0] shuffle_slots [DEPTH];
    logic [SAMPLE_W-1:0] prev_sample;

    number_t pending_numbers [$];
    int      error_count;
    bit      no_idle;

    // Directed words: first draw after reset, seed zero, seed equal to the modulus,
    // the largest legal seed, alternating bit patterns and draws with ignored seeds.
    // None of the resulting numbers can be read off by eye, so all go to the predictor.
    request_row_t directed_rows [20] = '{
        '{OP_DRAW,   31'd0},
        '{OP_DRAW,   31'h7FFF_FFFF},
        '{OP_DRAW,   31'd0},
        '{OP_RESEED, 31'd0},
        '{OP_DRAW,   31'd0},
        '{OP_RESEED, 31'd1},
        '{OP_DRAW,   31'h7FFF_FFFF},
        '{OP_RESEED, 31'h7FFF_FFFF},
        '{OP_RESEED, 31'h7FFF_FFFE},
        '{OP_DRAW,   31'd0},
        '{OP_RESEED, 31'h2AAA_AAAA},
        '{OP_RESEED, 31'h5555_5555},
        '{OP_DRAW,   31'h2AAA_AAAA},
        '{OP_RESEED, 31'd2},
        '{OP_RESEED, 31'd16807},
        '{OP_DRAW,   31'd0},
        '{OP_DRAW,   31'd0},
        '{OP_DRAW,   31'h5555_5555},
        '{OP_RESEED, 31'h4000_0000},
        '{OP_DRAW,   31'd0}
    };

    // One step of the multiplicative congruential generator.
    function automatic logic [SAMPLE_W-1:0] lcg_advance(input logic [SAMPLE_W-1:0] s);
        longint unsigned prod;
        prod = 64'(s);
        prod = (prod * LCG_MULT) % LCG_MOD;
        return prod[SAMPLE_W-1:0];
    endfunction

    // Works out the number that one accepted request word yields.
    task automatic predict_number(input logic op, input logic [SAMPLE_W-1:0] seed,
                                  output number_t num);
        logic [SAMPLE_W-1:0] s;
        longint unsigned     frac;
        int                  slot;
        int                  i;
        // Seeding on request or on the first draw after reset, then warm-up.
        if (op == OP_RESEED || prev_sample == '0)
        begin
            s = (seed == LCG_MOD) ? '0 : seed;
            if (s == '0)
                s = SAMPLE_W'(1);
            for (i = DEPTH + WARM_EXTRA - 1; i >= 0; i--)
            begin
                s = lcg_advance(s);
                if (i < DEPTH)
                    shuffle_slots[i] = s;
            end
            gen_state   = s;
            prev_sample = shuffle_slots[0];
        end
        // Shuffle: the previous sample picks the slot that is swapped out.
        gen_state = lcg_advance(gen_state);
        slot = prev_sample / SLOT_DIV;
        if (slot >= DEPTH)
            slot = DEPTH - 1;
        prev_sample         = shuffle_slots[slot];
        shuffle_slots[slot] = gen_state;
        frac = 64'(prev_sample);
        frac = (frac << FRAC_W) / LCG_MOD;
        if (frac > FRAC_MAX)
            frac = FRAC_MAX;
        num.sample   = prev_sample;
        num.fraction = frac[FRAC_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Offers one request word, with random idle cycles in front, and records its number.
    task automatic send_request(input logic op, input logic [SAMPLE_W-1:0] seed);
        number_t num;
        while (!no_idle && $urandom_range(0, 99) < 34)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid      = 1'b1;
        req.operation  = op;
        req.seed_value = seed;
        do
            @(posedge clk);
        while (!req.ready);
        predict_number(op, seed, num);
        pending_numbers.push_back(num);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_numbers.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure.
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            res.ready = no_idle || ($urandom_range(0, 99) >= 34);
        end
    end

    // Result checking against the oldest expected number.
    always @(posedge clk)
    begin
        number_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_numbers.size() == 0)
                report_mismatch("result word with none expected", 64'(res.sample), 64'(0));
            else
            begin
                want = pending_numbers.pop_front();
                if (res.sample !== want.sample)
                    report_mismatch("sample", 64'(res.sample), 64'(want.sample));
                if (res.fraction !== want.fraction)
                    report_mismatch("fraction", 64'(res.fraction), 64'(want.fraction));
            end
        end
    end

    // Stimulus: directed words, then random draws with occasional reseeds.
    initial
    begin
        logic                op;
        logic [SAMPLE_W-1:0] seed;
        int                  k;
        error_count    = 0;
        no_idle        = 1'b0;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.operation  = OP_DRAW;
        req.seed_value = '0;
        prev_sample    = '0;
        gen_state      = SAMPLE_W'(1);
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].seed);
        wait_for_drain();

        for (k = 0; k < N_RANDOM; k++)
        begin
            // A stretch in the middle runs with neither side idling.
            no_idle = (k >= 200 && k < 330);
            if (k == 400)
                wait_for_drain();
            op   = ($urandom_range(0, 99) < 12) ? OP_RESEED : OP_DRAW;
            seed = SAMPLE_W'($urandom);
            case ($urandom_range(0, 9))
                0: seed = SAMPLE_W'($urandom_range(0, 3));
                1: seed = SAMPLE_W'(LCG_MOD - $urandom_range(0, 3));
                default: ;
            endcase
            send_request(op, seed);
        end
        no_idle = 1'b0;

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
